// ----- src/assert_macros.svh -----
// Assertion macros shared by the estimator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FLSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FLSE_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define FLSE_ASSERT(lbl, clk, rst_n, prop)
`define FLSE_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ----- src/flse_pkg.sv -----
package flse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int WIDE_W = 128;

    typedef struct packed {
        logic [63:0] vyb;
        logic [51:0] vy2;
        logic [63:0] nvxb;
        logic [51:0] nvxvy;
        logic [51:0] vx2;
    } t_sums;

endpackage

// ----- src/flse_front.sv -----
module flse_front #(
    parameter int COORD_BITS = 10,
    parameter int FLOW_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [15:0]         i_flow_x,
    input  logic [15:0]         i_flow_y,
    input  logic [9:0]          i_pos_x,
    input  logic [9:0]          i_pos_y,
    input  logic                i_last_vector,
    output logic                o_push,
    output flse_pkg::t_sums     o_sums,
    output logic [1:0]          o_lasts
);
    import flse_pkg::*;

    localparam logic [9:0] CMASK = 10'((1 << COORD_BITS) - 1);
    localparam int SH = 16 - FLOW_BITS;

    logic [15:0]        w_ux, w_uy;
    logic signed [15:0] w_vx, w_vy;
    logic               r_v0, r_l0, r_v1, r_l1, r_v2, r_l2;
    logic signed [15:0] r_vx0, r_vy0, r_vx1, r_vy1;
    logic [9:0]         r_x0, r_y0;
    logic signed [26:0] w_p0, w_p1;
    logic signed [27:0] w_b, r_b1;
    logic signed [43:0] r_vyb2, r_vxb2;
    logic signed [31:0] r_vy22, r_vxvy2, r_vx22;
    t_sums              r_sum, w_next;

    assign w_ux = 16'(i_flow_x << SH);
    assign w_uy = 16'(i_flow_y << SH);
    assign w_vx = $signed(w_ux) >>> SH;
    assign w_vy = $signed(w_uy) >>> SH;

    assign w_p0 = $signed({1'b0, r_x0}) * r_vy0;
    assign w_p1 = $signed({1'b0, r_y0}) * r_vx0;
    assign w_b  = {w_p0[26], w_p0} - {w_p1[26], w_p1};

    always_comb begin
        w_next.vyb   = r_sum.vyb + {{20{r_vyb2[43]}}, r_vyb2};
        w_next.nvxb  = r_sum.nvxb - {{20{r_vxb2[43]}}, r_vxb2};
        w_next.vy2   = r_sum.vy2 + {{20{r_vy22[31]}}, r_vy22};
        w_next.nvxvy = r_sum.nvxvy - {{20{r_vxvy2[31]}}, r_vxvy2};
        w_next.vx2   = r_sum.vx2 + {{20{r_vx22[31]}}, r_vx22};
    end

    always_ff @(posedge i_clk) begin
        r_vx0 <= w_vx;
        r_vy0 <= w_vy;
        r_x0  <= i_pos_x & CMASK;
        r_y0  <= i_pos_y & CMASK;
        r_l0  <= i_last_vector;
        r_b1  <= w_b;
        r_vx1 <= r_vx0;
        r_vy1 <= r_vy0;
        r_l1  <= r_l0;
        r_vyb2  <= r_vy1 * r_b1;
        r_vxb2  <= r_vx1 * r_b1;
        r_vy22  <= r_vy1 * r_vy1;
        r_vxvy2 <= r_vx1 * r_vy1;
        r_vx22  <= r_vx1 * r_vx1;
        r_l2    <= r_l1;
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_sum <= '0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_sum <= r_l2 ? '0 : w_next;
            end
        end
    end

    assign o_push  = r_v2 & r_l2;
    assign o_sums  = w_next;
    assign o_lasts = 2'({1'b0, r_v0 & r_l0}) + 2'({1'b0, r_v1 & r_l1})
                   + 2'({1'b0, r_v2 & r_l2});

endmodule

// ----- src/flse_queue.sv -----
`include "assert_macros.svh"

module flse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  flse_pkg::t_sums i_data,
    input  logic            i_pop,
    output flse_pkg::t_sums o_data,
    output logic            o_empty,
    output logic [2:0]      o_count
);
    import flse_pkg::*;

    t_sums       r_mem [QUEUE_DEPTH];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'({2'b0, i_push}) - 3'({2'b0, i_pop});
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == 3'd0);
    assign o_count = r_cnt;

    `FLSE_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop && r_cnt == 3'(QUEUE_DEPTH))
    `FLSE_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && r_cnt == 3'd0)
    `FLSE_ASSERT(a_count_bound, i_clk, i_rst_n, r_cnt <= 3'(QUEUE_DEPTH))

endmodule

// ----- src/flse_back.sv -----
`include "assert_macros.svh"

module flse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  flse_pkg::t_sums    i_q_data,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [15:0] o_foe_x,
    output logic signed [15:0] o_foe_y,
    output logic               o_singular
);
    import flse_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DSET, S_DIV, S_OUT} t_state;

    t_state              r_state;
    t_sums               r_s;
    logic [1:0]          r_term;
    logic                r_half, r_dsel, r_neg, r_ov;
    logic [6:0]          r_bit;
    logic [WIDE_W-1:0]   r_acc, r_a, r_det, r_nx, r_ny, r_n, r_d, r_rem, r_q;
    logic [63:0]         r_b;
    logic [15:0]         r_fx, r_fy;
    logic [WIDE_W-1:0]   w_h0, w_h1, w_h2, w_h3, w_h4, w_a, w_part, w_num;
    logic [63:0]         w_b;
    logic                w_sub;
    logic [WIDE_W:0]     w_rsh;
    logic                w_ge;
    logic [WIDE_W-1:0]   w_qn;
    logic [15:0]         w_lim, w_mag, w_res;

    assign w_h0 = {{64{r_s.vyb[63]}}, r_s.vyb};
    assign w_h1 = {76'b0, r_s.vy2};
    assign w_h2 = {{64{r_s.nvxb[63]}}, r_s.nvxb};
    assign w_h3 = {{76{r_s.nvxvy[51]}}, r_s.nvxvy};
    assign w_h4 = {76'b0, r_s.vx2};

    always_comb begin
        unique case ({r_term, r_half})
            3'b000:  begin w_a = w_h1; w_b = w_h4[63:0]; end
            3'b001:  begin w_a = w_h3; w_b = w_h3[63:0]; end
            3'b010:  begin w_a = w_h0; w_b = w_h4[63:0]; end
            3'b011:  begin w_a = w_h2; w_b = w_h3[63:0]; end
            3'b100:  begin w_a = w_h2; w_b = w_h1[63:0]; end
            3'b101:  begin w_a = w_h0; w_b = w_h3[63:0]; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_sub  = (r_bit == 7'd63) ^ r_half;
    assign w_part = r_b[0] ? (w_sub ? -r_a : r_a) : '0;
    assign w_num  = r_dsel ? r_ny : r_nx;

    assign w_rsh = {r_rem, r_n[WIDE_W-1]};
    assign w_ge  = w_rsh >= {1'b0, r_d};
    assign w_qn  = {r_q[WIDE_W-2:0], w_ge};
    assign w_lim = r_neg ? 16'h8000 : 16'h7fff;
    assign w_mag = ((|w_qn[WIDE_W-1:16]) || (w_qn[15:0] > w_lim)) ? w_lim : w_qn[15:0];
    assign w_res = r_neg ? -w_mag : w_mag;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_s     <= i_q_data;
                        r_term  <= 2'd0;
                        r_half  <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_a     <= w_a;
                    r_b     <= w_b;
                    r_bit   <= 7'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_a   <= r_a << 1;
                    r_b   <= r_b >> 1;
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == 7'd63) begin
                        if (!r_half) begin
                            r_acc   <= r_acc + w_part;
                            r_half  <= 1'b1;
                            r_state <= S_LOAD;
                        end else begin
                            r_acc  <= '0;
                            r_half <= 1'b0;
                            r_term <= r_term + 2'd1;
                            unique case (r_term)
                                2'd0:    r_det <= r_acc + w_part;
                                2'd1:    r_nx  <= r_acc + w_part;
                                default: r_ny  <= r_acc + w_part;
                            endcase
                            if (r_term == 2'd2) begin
                                r_dsel  <= 1'b0;
                                r_state <= (r_det == '0) ? S_OUT : S_DSET;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end
                    end else begin
                        r_acc <= r_acc + w_part;
                    end
                end
                S_DSET: begin
                    r_n     <= w_num[WIDE_W-1] ? -w_num : w_num;
                    r_d     <= r_det[WIDE_W-1] ? -r_det : r_det;
                    r_neg   <= w_num[WIDE_W-1] ^ r_det[WIDE_W-1];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_bit   <= 7'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_n   <= r_n << 1;
                    r_rem <= w_ge ? WIDE_W'(w_rsh - {1'b0, r_d}) : w_rsh[WIDE_W-1:0];
                    r_q   <= w_qn;
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == 7'd127) begin
                        if (!r_dsel) begin
                            r_fx    <= w_res;
                            r_dsel  <= 1'b1;
                            r_state <= S_DSET;
                        end else begin
                            r_fy    <= w_res;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov       <= 1'b1;
                        o_singular <= (r_det == '0);
                        if (r_det == '0) begin
                            o_foe_x <= '0;
                            o_foe_y <= '0;
                        end else begin
                            o_foe_x <= r_fx;
                            o_foe_y <= r_fy;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty = !r_ov;

    `FLSE_ASSERT(a_singular_zero, i_clk, i_rst_n, (r_ov && o_singular) |-> (o_foe_x == 16'sd0 && o_foe_y == 16'sd0))
    `FLSE_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_det != '0))
    `FLSE_ASSERT(a_result_held, i_clk, i_rst_n, (r_ov && !i_pop) |=> (r_ov && $stable(o_foe_x) && $stable(o_foe_y)))

endmodule

// ----- src/foe_least_squares_estimator_top.sv -----
// A flow beat passes the front pipeline registers before it is accumulated. A last beat's
// result is computed by six shift-add products and then two bit-serial divisions; the
// divisions are skipped when the frame is singular. The front takes one flow beat per cycle
// while full is low; the solver works on one frame at a time and holds its result until the
// previous one is popped. Full rises when queued frames plus last beats still in the front
// pipeline reach four. Synchronous active-low reset clears the sums, the frame queue and the result-valid flag.
module foe_least_squares_estimator_top #(
    parameter int COORD_BITS = 10,
    parameter int FLOW_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_flow_x,
    input  logic signed [15:0] i_flow_y,
    input  logic [9:0]         i_pos_x,
    input  logic [9:0]         i_pos_y,
    input  logic               i_last_vector,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_foe_x,
    output logic signed [15:0] o_foe_y,
    output logic               o_singular
);
    import flse_pkg::*;

    logic        w_push, w_q_pop, w_q_empty;
    logic [1:0]  w_lasts;
    logic [2:0]  w_count;
    t_sums       w_sums, w_q_data;
    logic [3:0]  w_pending;

    assign w_pending = 4'({1'b0, w_count}) + 4'({2'b0, w_lasts});
    assign full      = (w_pending >= 4'(QUEUE_DEPTH));

    flse_front #(.COORD_BITS(COORD_BITS), .FLOW_BITS(FLOW_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (push && !full),
        .i_flow_x      (i_flow_x),
        .i_flow_y      (i_flow_y),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_last_vector (i_last_vector),
        .o_push        (w_push),
        .o_sums        (w_sums),
        .o_lasts       (w_lasts)
    );

    flse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_sums),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_count (w_count)
    );

    flse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_data),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_foe_x    (o_foe_x),
        .o_foe_y    (o_foe_y),
        .o_singular (o_singular)
    );

endmodule
